@@ rtl/parity_crc_hamming_framer_unit_defines.svh @@
// Assertion macros shared by the framer RTL.
`ifndef PARITY_CRC_HAMMING_FRAMER_UNIT_DEFINES_SVH
`define PARITY_CRC_HAMMING_FRAMER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising clock edge outside reset.
`define PCF_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framer check failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define PCF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("framer check failed");
`else
`define PCF_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define PCF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ rtl/pcf_pkg.sv @@
// Types, constants and coding functions of the framer.
`timescale 1ns / 1ps

package pcf_pkg;

   localparam int MAX_PAYLOAD = 64;

   localparam logic [6:0]  SYN_CHAR    = 7'd22;
   localparam logic [15:0] CRC_POLY    = 16'h8005;
   localparam logic [7:0]  PARITY_MARK = 8'h80;

   // Coding modes.
   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_CRC   = 2'd1;
   localparam logic [1:0] MODE_CHECK = 2'd2;

   // Symbol kinds.
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_CRC     = 2'd2;
   localparam logic [1:0] KIND_CHECK   = 2'd3;

   // Register index of the coding mode register (address bit 2).
   localparam logic CSR_CODING_MODE = 1'b0;

   typedef struct packed {
      logic [6:0] data_byte;
      logic       first_of_frame;
      logic       last_of_frame;
      logic [6:0] payload_count;
   } req_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic [1:0] symbol_kind;
      logic       frame_end;
      logic       run_last;
   } rsp_type;

   // One classified request, handed from the front end to the back end.
   typedef struct packed {
      logic [7:0]  sym;
      logic [3:0]  chk;
      logic [15:0] crc;
      logic [7:0]  mode_code;
      logic [7:0]  len_code;
      logic [1:0]  mode;
      logic        first;
      logic        last;
   } job_type;

   // Seven data bits with bit 7 chosen so that the byte has odd parity.
   function automatic logic [7:0] odd_code(input logic [6:0] d);
      odd_code = {~^d, d};
   endfunction

   // One byte through the CRC-16, MSB first.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      r = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (r[15]) begin
            r = {r[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      crc_feed = r;
   endfunction

   // Inverted check bits, c0 in bit 0.
   function automatic logic [3:0] check_bits(input logic [7:0] v);
      check_bits[0] = ~(v[7] ^ v[6] ^ v[4] ^ v[3] ^ v[1]);
      check_bits[1] = ~(v[7] ^ v[5] ^ v[4] ^ v[2] ^ v[1]);
      check_bits[2] = ~(v[6] ^ v[5] ^ v[4] ^ v[0]);
      check_bits[3] = ~(v[3] ^ v[2] ^ v[1] ^ v[0]);
   endfunction

endpackage

@@ rtl/pcf_front.sv @@
// Front end: codes each request, runs the CRC and builds a job for the back end.
`timescale 1ns / 1ps

module pcf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  pcf_pkg::req_type  req,
   input  logic [1:0]        mode,
   output pcf_pkg::job_type  job
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [7:0]  sym;
   logic [6:0]  len;

   always_comb begin
      sym = pcf_pkg::odd_code(req.data_byte);
      // The CRC restarts from zero on the first byte of a frame.
      crc_in = pcf_pkg::crc_feed(req.first_of_frame ? 16'h0000 : crc_ff, sym);

      len = (req.payload_count > 7'(pcf_pkg::MAX_PAYLOAD)) ?
            7'(pcf_pkg::MAX_PAYLOAD) : req.payload_count;
      if (mode == pcf_pkg::MODE_CRC) begin
         len = len + 7'd2;
      end

      job.sym       = sym;
      job.chk       = pcf_pkg::check_bits(sym);
      job.crc       = crc_in;
      job.mode_code = pcf_pkg::odd_code({5'd0, mode});
      job.len_code  = pcf_pkg::odd_code(len);
      job.mode      = mode;
      job.first     = req.first_of_frame;
      job.last      = req.last_of_frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= 16'h0000;
      end else if (accept) begin
         crc_ff <= crc_in;
      end
   end

endmodule

@@ rtl/pcf_queue.sv @@
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module pcf_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pcf_pkg::job_type  push_job,
   input  logic              pop,
   output pcf_pkg::job_type  head_job,
   output logic              full,
   output logic              empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   pcf_pkg::job_type mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff;
   logic [PtrW-1:0]  rd_ptr_ff;
   logic [CntW-1:0]  count_ff;

   assign full     = (count_ff == CntW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ rtl/pcf_back.sv @@
// Back end: walks each job's symbols into the result register, one per cycle when not stalled by rsp_pop.
`timescale 1ns / 1ps

module pcf_back (
   input  logic              clock,
   input  logic              reset,
   input  pcf_pkg::job_type  head_job,
   input  logic              q_empty,
   output logic              q_pop,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output pcf_pkg::rsp_type  rsp_data
);

   typedef enum logic [3:0] {
      ST_SYN0, ST_SYN1, ST_MODE, ST_LEN, ST_DATA,
      ST_TAIL0, ST_TAIL1, ST_TAIL2, ST_TAIL3
   } step_type;

   logic              busy_ff;
   step_type          step_ff;
   pcf_pkg::job_type  job_ff;
   logic              out_valid_ff;
   pcf_pkg::rsp_type  out_ff;

   logic              advance;
   logic              final_sym;
   step_type          step_in;
   pcf_pkg::rsp_type  sym_in;

   always_comb begin
      sym_in    = '0;
      final_sym = 1'b0;
      step_in   = step_ff;
      unique case (step_ff)
         ST_SYN0: begin
            sym_in.symbol      = pcf_pkg::odd_code(pcf_pkg::SYN_CHAR);
            sym_in.symbol_kind = pcf_pkg::KIND_HEADER;
            step_in            = ST_SYN1;
         end
         ST_SYN1: begin
            sym_in.symbol      = pcf_pkg::odd_code(pcf_pkg::SYN_CHAR);
            sym_in.symbol_kind = pcf_pkg::KIND_HEADER;
            step_in            = ST_MODE;
         end
         ST_MODE: begin
            sym_in.symbol      = job_ff.mode_code;
            sym_in.symbol_kind = pcf_pkg::KIND_HEADER;
            step_in            = ST_LEN;
         end
         ST_LEN: begin
            sym_in.symbol      = job_ff.len_code;
            sym_in.symbol_kind = pcf_pkg::KIND_HEADER;
            step_in            = ST_DATA;
         end
         ST_DATA: begin
            sym_in.symbol      = job_ff.sym;
            sym_in.symbol_kind = pcf_pkg::KIND_PAYLOAD;
            final_sym = (job_ff.mode != pcf_pkg::MODE_CHECK) &&
                        !(job_ff.mode == pcf_pkg::MODE_CRC && job_ff.last);
            sym_in.frame_end = job_ff.last && (job_ff.mode != pcf_pkg::MODE_CRC) &&
                               (job_ff.mode != pcf_pkg::MODE_CHECK);
            step_in = ST_TAIL0;
         end
         ST_TAIL0: begin
            if (job_ff.mode == pcf_pkg::MODE_CHECK) begin
               sym_in.symbol      = {7'd0, job_ff.chk[0]};
               sym_in.symbol_kind = pcf_pkg::KIND_CHECK;
            end else begin
               sym_in.symbol      = job_ff.crc[15:8];
               sym_in.symbol_kind = pcf_pkg::KIND_CRC;
            end
            step_in = ST_TAIL1;
         end
         ST_TAIL1: begin
            if (job_ff.mode == pcf_pkg::MODE_CHECK) begin
               sym_in.symbol      = {7'd0, job_ff.chk[1]};
               sym_in.symbol_kind = pcf_pkg::KIND_CHECK;
            end else begin
               // Low CRC byte closes a CRC-coded frame.
               sym_in.symbol      = job_ff.crc[7:0];
               sym_in.symbol_kind = pcf_pkg::KIND_CRC;
               sym_in.frame_end   = 1'b1;
               final_sym          = 1'b1;
            end
            step_in = ST_TAIL2;
         end
         ST_TAIL2: begin
            sym_in.symbol      = {7'd0, job_ff.chk[2]};
            sym_in.symbol_kind = pcf_pkg::KIND_CHECK;
            step_in            = ST_TAIL3;
         end
         ST_TAIL3: begin
            sym_in.symbol      = {7'd0, job_ff.chk[3]};
            sym_in.symbol_kind = pcf_pkg::KIND_CHECK;
            sym_in.frame_end   = job_ff.last;
            final_sym          = 1'b1;
         end
         default: begin
            final_sym = 1'b1;
         end
      endcase
      sym_in.run_last = final_sym;
   end

   assign advance   = busy_ff && (!out_valid_ff || rsp_pop);
   assign q_pop     = !q_empty && (!busy_ff || (advance && final_sym));
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= ST_SYN0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            out_valid_ff <= 1'b1;
            out_ff       <= sym_in;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end

         if (q_pop) begin
            busy_ff <= 1'b1;
            job_ff  <= head_job;
            step_ff <= head_job.first ? ST_SYN0 : ST_DATA;
         end else if (advance) begin
            if (final_sym) begin
               busy_ff <= 1'b0;
            end
            step_ff <= step_in;
         end
      end
   end

endmodule

@@ rtl/parity_crc_hamming_framer_unit.sv @@
// Top level of the framer: configuration register, front end, job queue, back end.
`timescale 1ns / 1ps
`include "parity_crc_hamming_framer_unit_defines.svh"

// The framer turns seven-bit payload characters into frame symbols. Each
// request carries one character. The first request of a frame also causes a
// four-symbol header (SYN, SYN, coding mode, frame length). Every header and
// payload symbol has bit 7 chosen so that the byte has odd parity. With coding
// mode 1 the two CRC-16 bytes follow the last payload symbol. With mode 2
// each payload symbol is followed by four check-bit symbols of value 0 or 1.
// A request therefore causes between one and nine results, and the back end
// emits one symbol per clock cycle while the result register is free or
// being popped. The front end takes a new request every cycle while the job
// queue has room, so requests pile up behind a long header or check-bit run
// only up to the queue depth. A request accepted by an idle framer goes into
// the job queue, then moves from the queue into the back end, and then its
// first symbol is put into the output register. After that, the back end
// goes straight from one job's last symbol to the next job's first, so jobs
// follow each other without a gap. The coding mode register sits at address 0
// and must only be written while the framer is idle. The CRC restarts on each
// frame's first character.

module parity_crc_hamming_framer_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_push,
   output logic              req_full,
   input  pcf_pkg::req_type  req_data,

   output logic              rsp_empty,
   input  logic              rsp_pop,
   output pcf_pkg::rsp_type  rsp_data,

   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [1:0]        coding_mode_ff;
   logic              csr_write;
   logic              req_accept;
   pcf_pkg::job_type  front_job;
   pcf_pkg::job_type  head_job;
   logic              q_empty;
   logic              q_pop;
   logic              rsp_valid;
   logic              end_shown;
   logic              check_shown;
   logic              coded_shown;
   logic              run_moves;

   // The single configuration register, decoded on address bit 2; writes with bit 2 set are dropped.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == pcf_pkg::CSR_CODING_MODE);
   assign csr_prdata = (csr_paddr[2] == pcf_pkg::CSR_CODING_MODE) ?
                       {30'd0, coding_mode_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         coding_mode_ff <= pcf_pkg::MODE_NONE;
      end else if (csr_write) begin
         coding_mode_ff <= csr_pwdata[1:0];
      end
   end

   // A request is taken whenever the job queue has room.
   assign req_accept = req_push && !req_full;

   pcf_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .req    (req_data),
      .mode   (coding_mode_ff),
      .job    (front_job)
   );

   pcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_accept),
      .push_job (front_job),
      .pop      (q_pop),
      .head_job (head_job),
      .full     (req_full),
      .empty    (q_empty)
   );

   pcf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   // Conditions on the symbol currently shown on the result ports.
   assign rsp_valid   = !rsp_empty;
   assign end_shown   = rsp_valid && rsp_data.frame_end;
   assign check_shown = rsp_valid && (rsp_data.symbol_kind == pcf_pkg::KIND_CHECK);
   assign coded_shown = rsp_valid && ((rsp_data.symbol_kind == pcf_pkg::KIND_HEADER) ||
                                      (rsp_data.symbol_kind == pcf_pkg::KIND_PAYLOAD));
   assign run_moves   = rsp_pop && rsp_valid && !rsp_data.run_last;

   // A frame always ends on the last symbol of the request that closes it.
   `PCF_ASSERT_IMPLIES(a_end_is_run_last, clock, reset, end_shown, rsp_data.run_last)
   // Check-bit symbols carry a single bit.
   `PCF_ASSERT_IMPLIES(a_check_bit_narrow, clock, reset, check_shown, rsp_data.symbol[7:1] == 7'd0)
   // Header and payload symbols have odd parity.
   `PCF_ASSERT_IMPLIES(a_odd_parity, clock, reset, coded_shown, ^rsp_data.symbol)
   // The symbols of one request come without a gap.
   `PCF_ASSERT_NEXT(a_run_continues, clock, reset, run_moves, rsp_valid)

endmodule

@@ tb/tb.sv @@
// Self-checking testbench of the framer: a directed table, then random frames under idling phases.
`timescale 1ns / 1ps

module tb;

   // The register takes values up to 3; the package names only the first three.
   localparam logic [1:0] MODE_THREE  = 2'd3;
   localparam logic [2:0] MODE_ADDR   = {pcf_pkg::CSR_CODING_MODE, 2'b00};
   localparam int         STALL_LIMIT = 2000;
   localparam int         TAIL_CYCLES = 20;
   localparam int         PHASE_ITEMS = 42;
   localparam int         NUM_PHASES  = 8;

   typedef struct {
      logic [1:0]       mode;
      pcf_pkg::req_type req;
      bit               pinned;
      pcf_pkg::rsp_type first_sym;
   } directed_row_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_push    = 1'b0;
   logic             req_full;
   pcf_pkg::req_type req_data    = '0;
   logic             rsp_empty;
   logic             rsp_pop     = 1'b0;
   pcf_pkg::rsp_type rsp_data;
   logic             csr_psel    = 1'b0;
   logic             csr_penable = 1'b0;
   logic             csr_pwrite  = 1'b0;
   logic [2:0]       csr_paddr   = '0;
   logic [31:0]      csr_pwdata  = '0;
   logic [31:0]      csr_prdata;
   logic             csr_pready;

   // Symbols still owed by the framer, oldest first.
   pcf_pkg::rsp_type expected_symbols[$];
   directed_row_type directed_rows[$];

   // Predictor state: running CRC and the coding mode the framer holds.
   logic [15:0] crc_state = '0;
   logic [1:0]  mode_now  = pcf_pkg::MODE_NONE;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int errors        = 0;
   int quiet_cycles  = 0;

   // Idling schedule and coding mode of each random phase.
   logic [1:0] phase_mode [NUM_PHASES] = '{pcf_pkg::MODE_NONE, pcf_pkg::MODE_CRC,
                                           pcf_pkg::MODE_CHECK, MODE_THREE,
                                           pcf_pkg::MODE_CHECK, pcf_pkg::MODE_CRC,
                                           pcf_pkg::MODE_NONE, pcf_pkg::MODE_CHECK};
   int phase_send_pct [NUM_PHASES] = '{0, 78, 0, 15, 0, 15, 0, 78};
   int phase_recv_pct [NUM_PHASES] = '{0, 0, 78, 15, 0, 15, 78, 0};

   parity_crc_hamming_framer_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Seven data bits with bit 7 raised whenever that makes the byte's parity odd.
   function automatic logic [7:0] parity_coded(input logic [6:0] d);
      logic [7:0] v;
      v = {1'b0, d};
      if (!(^d)) begin
         v = v | pcf_pkg::PARITY_MARK;
      end
      return v;
   endfunction

   // Bit-serial CRC-16 update, most significant bit of the byte first.
   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ b[i];
         r  = {r[14:0], 1'b0};
         if (fb) begin
            r = r ^ pcf_pkg::CRC_POLY;
         end
      end
      return r;
   endfunction

   function automatic void owe_symbol(input logic [7:0] sym, input logic [1:0] kind,
                                      input logic fe);
      pcf_pkg::rsp_type s;
      s.symbol      = sym;
      s.symbol_kind = kind;
      s.frame_end   = fe;
      s.run_last    = 1'b0;
      expected_symbols.push_back(s);
   endfunction

   // Appends the symbols that one request causes and returns how many there are.
   function automatic int predict_symbols(input pcf_pkg::req_type r);
      logic [6:0]       len;
      logic [7:0]       coded;
      pcf_pkg::rsp_type tail;
      int               before_n;
      before_n = expected_symbols.size();
      if (r.first_of_frame) begin
         len = (r.payload_count > 7'(pcf_pkg::MAX_PAYLOAD)) ?
               7'(pcf_pkg::MAX_PAYLOAD) : r.payload_count;
         if (mode_now == pcf_pkg::MODE_CRC) begin
            len = len + 7'd2;
         end
         crc_state = '0;
         owe_symbol(parity_coded(pcf_pkg::SYN_CHAR), pcf_pkg::KIND_HEADER, 1'b0);
         owe_symbol(parity_coded(pcf_pkg::SYN_CHAR), pcf_pkg::KIND_HEADER, 1'b0);
         owe_symbol(parity_coded({5'b0, mode_now}), pcf_pkg::KIND_HEADER, 1'b0);
         owe_symbol(parity_coded(len), pcf_pkg::KIND_HEADER, 1'b0);
      end
      coded     = parity_coded(r.data_byte);
      crc_state = crc16_update(crc_state, coded);
      owe_symbol(coded, pcf_pkg::KIND_PAYLOAD,
                 r.last_of_frame && mode_now != pcf_pkg::MODE_CRC &&
                 mode_now != pcf_pkg::MODE_CHECK);
      if (mode_now == pcf_pkg::MODE_CHECK) begin
         owe_symbol({7'b0, ~(coded[7] ^ coded[6] ^ coded[4] ^ coded[3] ^ coded[1])},
                    pcf_pkg::KIND_CHECK, 1'b0);
         owe_symbol({7'b0, ~(coded[7] ^ coded[5] ^ coded[4] ^ coded[2] ^ coded[1])},
                    pcf_pkg::KIND_CHECK, 1'b0);
         owe_symbol({7'b0, ~(coded[6] ^ coded[5] ^ coded[4] ^ coded[0])},
                    pcf_pkg::KIND_CHECK, 1'b0);
         owe_symbol({7'b0, ~(coded[3] ^ coded[2] ^ coded[1] ^ coded[0])},
                    pcf_pkg::KIND_CHECK, r.last_of_frame);
      end else if (mode_now == pcf_pkg::MODE_CRC && r.last_of_frame) begin
         owe_symbol(crc_state[15:8], pcf_pkg::KIND_CRC, 1'b0);
         owe_symbol(crc_state[7:0], pcf_pkg::KIND_CRC, 1'b1);
      end
      tail = expected_symbols.pop_back();
      tail.run_last = 1'b1;
      expected_symbols.push_back(tail);
      return expected_symbols.size() - before_n;
   endfunction

   function automatic void add_row(input logic [1:0] mode, input logic [6:0] data,
                                   input logic first, input logic last,
                                   input logic [6:0] count, input bit pinned = 1'b0,
                                   input logic [7:0] sym = '0, input logic [1:0] kind = '0,
                                   input logic fe = 1'b0, input logic rl = 1'b0);
      directed_row_type row;
      row.mode                     = mode;
      row.req.data_byte            = data;
      row.req.first_of_frame       = first;
      row.req.last_of_frame        = last;
      row.req.payload_count        = count;
      row.pinned                   = pinned;
      row.first_sym.symbol         = sym;
      row.first_sym.symbol_kind    = kind;
      row.first_sym.frame_end      = fe;
      row.first_sym.run_last       = rl;
      directed_rows.push_back(row);
   endfunction

   // Offers one request, with an optional idle gap first, and books its symbols once taken.
   // A pinned row replaces the first predicted symbol with the value typed in the table.
   task automatic send_request(input pcf_pkg::req_type r, input bit pinned,
                               input pcf_pkg::rsp_type pin);
      int n;
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_data <= r;
      req_push <= 1'b1;
      do @(posedge clock); while (!(req_push && !req_full));
      n = predict_symbols(r);
      if (pinned) begin
         expected_symbols[expected_symbols.size() - n] = pin;
      end
   endtask

   // Holds off new requests until every owed symbol has come out. The queue is looked at
   // on the falling edge, after the result side has settled for the cycle.
   task automatic drain_results();
      req_push <= 1'b0;
      do @(negedge clock); while (expected_symbols.size() != 0);
      @(posedge clock);
   endtask

   task automatic csr_read_check(input logic [1:0] want);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= MODE_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {30'b0, want}) begin
         $display("%0t: coding_mode read back expected %h actual %h",
                  $time, {30'b0, want}, csr_prdata);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_write_mode(input logic [1:0] m);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= MODE_ADDR;
      csr_pwdata  <= {30'b0, m};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      mode_now = m;
      @(posedge clock);
      csr_read_check(m);
   endtask

   // Result side: takes symbols with random stalls, checks each against the oldest owed one,
   // and ends the run when neither side has moved for too long.
   always @(posedge clock) begin
      pcf_pkg::rsp_type want;
      if (reset) begin
         quiet_cycles = 0;
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_symbols.size() == 0) begin
               $display("%0t: symbol with nothing owed: expected none actual %h/%0d/%b/%b",
                        $time, rsp_data.symbol, rsp_data.symbol_kind,
                        rsp_data.frame_end, rsp_data.run_last);
               errors++;
            end else begin
               want = expected_symbols.pop_front();
               if (rsp_data.symbol !== want.symbol ||
                   rsp_data.symbol_kind !== want.symbol_kind ||
                   rsp_data.frame_end !== want.frame_end ||
                   rsp_data.run_last !== want.run_last) begin
                  $display({"%0t: symbol/kind/frame_end/run_last expected %h/%0d/%b/%b",
                            " actual %h/%0d/%b/%b"},
                           $time, want.symbol, want.symbol_kind, want.frame_end,
                           want.run_last, rsp_data.symbol, rsp_data.symbol_kind,
                           rsp_data.frame_end, rsp_data.run_last);
                  errors++;
               end
            end
         end
         if ((rsp_pop && !rsp_empty) || (req_push && !req_full)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no request or symbol moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL parity_crc_hamming_framer_unit");
            $finish;
         end
      end
   end

   initial begin
      directed_row_type row;
      pcf_pkg::req_type r;
      int               frame_len;
      int               sent;
      logic [6:0]       count;

      // A character with no frame open, straight after reset.
      add_row(pcf_pkg::MODE_NONE, 7'h00, 1'b0, 1'b0, 7'd0, 1'b1, 8'h80,
              pcf_pkg::KIND_PAYLOAD, 1'b0, 1'b1);
      add_row(pcf_pkg::MODE_NONE, 7'h7F, 1'b1, 1'b1, 7'd1, 1'b1, 8'h16,
              pcf_pkg::KIND_HEADER, 1'b0, 1'b0);
      // Zero count in the header.
      add_row(pcf_pkg::MODE_NONE, 7'h55, 1'b1, 1'b0, 7'd0);
      add_row(pcf_pkg::MODE_NONE, 7'h2A, 1'b0, 1'b1, 7'd5, 1'b1, 8'h2A,
              pcf_pkg::KIND_PAYLOAD, 1'b1, 1'b1);
      // Count beyond the maximum is saturated.
      add_row(pcf_pkg::MODE_NONE, 7'h01, 1'b1, 1'b1, 7'd127);
      add_row(pcf_pkg::MODE_CRC, 7'h7F, 1'b1, 1'b0, 7'd64, 1'b1, 8'h16,
              pcf_pkg::KIND_HEADER, 1'b0, 1'b0);
      add_row(pcf_pkg::MODE_CRC, 7'h00, 1'b0, 1'b0, 7'd0);
      add_row(pcf_pkg::MODE_CRC, 7'h41, 1'b0, 1'b1, 7'd0);
      add_row(pcf_pkg::MODE_CRC, 7'h00, 1'b1, 1'b1, 7'd127);
      add_row(pcf_pkg::MODE_CRC, 7'h7F, 1'b1, 1'b1, 7'd0);
      add_row(pcf_pkg::MODE_CHECK, 7'h00, 1'b1, 1'b0, 7'd3);
      add_row(pcf_pkg::MODE_CHECK, 7'h7F, 1'b0, 1'b0, 7'd0);
      add_row(pcf_pkg::MODE_CHECK, 7'h5A, 1'b0, 1'b1, 7'd0);
      add_row(pcf_pkg::MODE_CHECK, 7'h33, 1'b1, 1'b1, 7'd65);
      // The unnamed fourth mode: its value goes into the header, the frame is left uncoded.
      add_row(MODE_THREE, 7'h11, 1'b1, 1'b0, 7'd2);
      add_row(MODE_THREE, 7'h6E, 1'b0, 1'b1, 7'd0);
      // Coding mode changed between characters of one frame.
      add_row(pcf_pkg::MODE_CRC, 7'h10, 1'b1, 1'b0, 7'd4);
      add_row(pcf_pkg::MODE_CHECK, 7'h20, 1'b0, 1'b0, 7'd0);
      add_row(pcf_pkg::MODE_NONE, 7'h30, 1'b0, 1'b0, 7'd0);
      add_row(pcf_pkg::MODE_CRC, 7'h40, 1'b0, 1'b1, 7'd0);
      // More characters than the header announced.
      add_row(pcf_pkg::MODE_NONE, 7'h03, 1'b1, 1'b0, 7'd2);
      add_row(pcf_pkg::MODE_NONE, 7'h04, 1'b0, 1'b0, 7'd0);
      add_row(pcf_pkg::MODE_NONE, 7'h05, 1'b0, 1'b1, 7'd0);
      // Frame closed in CRC mode without a start: the CRC carries on from the last frame.
      add_row(pcf_pkg::MODE_CRC, 7'h7E, 1'b0, 1'b1, 7'd0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      csr_read_check(pcf_pkg::MODE_NONE);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.mode != mode_now) begin
            drain_results();
            csr_write_mode(row.mode);
         end
         send_request(row.req, row.pinned, row.first_sym);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_results();
         send_idle_pct = phase_send_pct[p];
         recv_idle_pct = phase_recv_pct[p];
         csr_write_mode(phase_mode[p]);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(99) < 15) begin
               // Noise: frame flags in any combination.
               r.data_byte      = 7'($urandom);
               r.first_of_frame = 1'($urandom);
               r.last_of_frame  = 1'($urandom);
               r.payload_count  = 7'($urandom);
               send_request(r, 1'b0, '0);
               sent++;
            end else begin
               frame_len = ($urandom_range(9) == 0) ? $urandom_range(9, 20)
                                                    : $urandom_range(1, 6);
               count = ($urandom_range(9) == 0) ? 7'($urandom) : 7'(frame_len);
               for (int k = 0; k < frame_len; k++) begin
                  r.data_byte      = 7'($urandom);
                  r.first_of_frame = (k == 0);
                  r.last_of_frame  = (k == frame_len - 1);
                  r.payload_count  = (k == 0) ? count : 7'($urandom);
                  send_request(r, 1'b0, '0);
                  sent++;
               end
            end
            if ($urandom_range(99) < 4) begin
               drain_results();
            end
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && expected_symbols.size() == 0) begin
         $display("PASS parity_crc_hamming_framer_unit");
      end else begin
         $display("FAIL parity_crc_hamming_framer_unit");
      end
      $finish;
   end

endmodule
